// ----- hw/rtl/sdf_pkg.sv -----
// Shared types, codes and sizes for the set difference filter.
`default_nettype none

package sdf_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int VALUE_W     = 32;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 3;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_KEPT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [VALUE_W-1:0] item_value;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] result_value;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sdf_store.sv -----
// Subtrahend store: one write port, one read port with registered read data.
`default_nettype none

module sdf_store #(
	parameter int DEPTH  = sdf_pkg::STORE_DEPTH,
	parameter int ADDR_W = 8
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [ADDR_W-1:0]           wr_addr,
	input  wire logic [sdf_pkg::VALUE_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [ADDR_W-1:0]           rd_addr,
	output logic      [sdf_pkg::VALUE_W-1:0] rd_data
);
	import sdf_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/set_difference_filter.sv -----
// Set difference filter: subtrahend store with a linear search per minuend request.
//
// Input channel item_valid/item_ready/item carries a command and a value.
// Output channel result_valid/result_ready/result carries a status and the value.
// A load request appends its value to the store (or reports full), a test
// request searches entries 0 .. count-1 one per cycle through the store's
// single read port, and a clear request empties the store.
// A test ends its search early on the first match; a test on an empty store
// goes straight to its result. One request is in work at a time; the next is
// accepted as soon as the previous result has moved to the output register,
// even if that register still waits on result_ready.
// A stalled receiver holds the result register; a finished request then waits
// in the finish state until the register frees.
// Reset empties the store (count zero) and drops any pending result; store
// contents are not cleared, only entries below the count are ever read.
// Command code 3 is taken and produces no result.
`default_nettype none

module set_difference_filter #(
	parameter int STORE_DEPTH = sdf_pkg::STORE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire sdf_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output sdf_pkg::result_t      result
);
	import sdf_pkg::*;

	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    issue_idx_q;
	logic                rd_valid_s1;
	logic                rd_last_s1;
	logic [VALUE_W-1:0]  val_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  rd_data;
	logic                accept;
	logic                issue;
	logic                hit;
	logic                scan_done;
	logic                out_free;
	logic                wr_en;
	logic                not_full;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign not_full   = (count_q < CNT_W'(STORE_DEPTH));
	assign wr_en      = accept && (item.command == CMD_LOAD) && not_full;
	assign issue      = (state_q == S_SCAN) && (issue_idx_q < count_q);
	assign hit        = rd_valid_s1 && (rd_data == val_q);
	assign scan_done  = rd_valid_s1 && (hit || rd_last_s1);
	assign out_free   = !result_valid || result_ready;

	sdf_store #(
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (item.item_value),
		.rd_en   (issue),
		.rd_addr (issue_idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			issue_idx_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					issue_idx_q <= '0;
					rd_valid_s1 <= 1'b0;
					if (accept) begin
						case (item.command)
							CMD_LOAD: begin
								if (not_full) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= S_FINISH;
							end
							CMD_TEST: begin
								state_q <= (count_q == '0) ? S_FINISH : S_SCAN;
							end
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_FINISH;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Advance the read pointer; stop issuing once the search ends
					if (issue) begin
						issue_idx_q <= issue_idx_q + CNT_W'(1);
					end
					rd_valid_s1 <= issue && !scan_done;
					if (scan_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					rd_valid_s1 <= 1'b0;
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request value and status travel with the request; no reset needed
	always_ff @(posedge clk) begin
		rd_last_s1 <= (issue_idx_q == count_q - CNT_W'(1));
		if (accept) begin
			val_q <= (item.command == CMD_CLEAR) ? '0 : item.item_value;
			case (item.command)
				CMD_LOAD:  status_q <= not_full ? ST_LOADED : ST_FULL;
				CMD_TEST:  status_q <= ST_KEPT;
				CMD_CLEAR: status_q <= ST_CLEARED;
				default:   status_q <= ST_KEPT;
			endcase
		end else if ((state_q == S_SCAN) && scan_done) begin
			status_q <= hit ? ST_REMOVED : ST_KEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if ((state_q == S_FINISH) && out_free) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && out_free) begin
			result.status       <= status_q;
			result.result_value <= val_q;
		end
	end

endmodule

`default_nettype wire

// ----- dv/set_difference_filter_test.sv -----
// Self-checking testbench for the set difference filter: directed and random requests of all codes.
`timescale 1ns / 100ps

class difference_scoreboard;
	logic [sdf_pkg::VALUE_W-1:0] subtrahends [sdf_pkg::STORE_DEPTH];
	int unsigned                 stored;
	sdf_pkg::result_t            awaited [$];
	int unsigned                 mismatches;

	function new();
		stored     = 0;
		mismatches = 0;
	endfunction

	function int unsigned pending();
		return awaited.size();
	endfunction

	// Update the predicted store and queue the outcome of one accepted request (none for the unused code).
	function void note_request(sdf_pkg::item_t req);
		sdf_pkg::result_t outcome;
		bit               found;
		outcome.result_value = req.item_value;
		case (req.command)
			sdf_pkg::CMD_LOAD: begin
				if (stored < sdf_pkg::STORE_DEPTH) begin
					subtrahends[stored] = req.item_value;
					stored++;
					outcome.status = sdf_pkg::ST_LOADED;
				end else begin
					outcome.status = sdf_pkg::ST_FULL;
				end
				awaited.push_back(outcome);
			end
			sdf_pkg::CMD_TEST: begin
				found = 1'b0;
				for (int unsigned i = 0; i < stored; i++)
					if (subtrahends[i] == req.item_value)
						found = 1'b1;
				outcome.status = found ? sdf_pkg::ST_REMOVED : sdf_pkg::ST_KEPT;
				awaited.push_back(outcome);
			end
			sdf_pkg::CMD_CLEAR: begin
				stored               = 0;
				outcome.status       = sdf_pkg::ST_CLEARED;
				outcome.result_value = '0;
				awaited.push_back(outcome);
			end
			default: ;
		endcase
	endfunction

	function void check_result(sdf_pkg::result_t got);
		sdf_pkg::result_t want;
		if (awaited.size() == 0) begin
			$error("result with no request waiting: status %0d, result_value %0d",
				got.status, got.result_value);
			mismatches++;
			return;
		end
		want = awaited.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			mismatches++;
		end
		if (got.result_value !== want.result_value) begin
			$error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
			mismatches++;
		end
	endfunction
endclass

module set_difference_filter_test;
	import sdf_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	difference_scoreboard sb;

	set_difference_filter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Check results before noting requests taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(result);
			if (item_valid && item_ready)
				sb.note_request(item);
		end
	end

	initial begin
		#25_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(5))
			0: begin
				case ($urandom_range(4))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = '0;
					3: v = '1;
					default: v = 32'd1;
				endcase
			end
			1: begin
				// narrow range so that tests hit stored values often
				v = $urandom_range(15);
				v = v - 32'd8;
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// Hold valid and payload until the request is taken.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
		item_t req;
		req.command    = cmd;
		req.item_value = value;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Mostly clear/load/test sequences; the rest is random noise.
	task automatic run_sequences(input int unsigned quota, input bit start_full);
		logic [VALUE_W-1:0] loaded [$];
		logic [VALUE_W-1:0] v;
		logic [CMD_W-1:0]   c;
		int unsigned        sent;
		int unsigned        n_loads;
		bit                 fill;
		sent = 0;
		fill = start_full;
		while (sent < quota) begin
			if ($urandom_range(99) < 80) begin
				if (fill || $urandom_range(99) < 70) begin
					send_request(CMD_CLEAR, $urandom());
					loaded.delete();
					sent++;
				end
				n_loads = fill ? STORE_DEPTH + $urandom_range(1, 4) : $urandom_range(0, 12);
				repeat (n_loads) begin
					v = pick_value();
					loaded.push_back(v);
					send_request(CMD_LOAD, v);
					sent++;
				end
				repeat ($urandom_range(1, 12)) begin
					if (loaded.size() != 0 && $urandom_range(1) == 1)
						v = loaded[$urandom_range(loaded.size() - 1)];
					else
						v = pick_value();
					send_request(CMD_TEST, v);
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					c = CMD_W'($urandom_range(3));
					v = pick_value();
					send_request(c, v);
					if (c == CMD_LOAD)
						loaded.push_back(v);
					else if (c == CMD_CLEAR)
						loaded.delete();
					if (c != CMD_UNUSED)
						sent++;
				end
			end
			fill = ($urandom_range(99) < 2);
		end
	endtask

	initial begin
		int unsigned waited;
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		result_ready  = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 65;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_request(CMD_TEST, '0);
		send_request(CMD_TEST, VAL_MIN);
		send_request(CMD_CLEAR, '1);
		send_request(CMD_LOAD, VAL_MIN);
		send_request(CMD_LOAD, VAL_MAX);
		send_request(CMD_LOAD, '0);
		send_request(CMD_LOAD, '1);
		send_request(CMD_LOAD, VAL_MAX);
		send_request(CMD_TEST, VAL_MIN);
		send_request(CMD_TEST, VAL_MAX);
		send_request(CMD_TEST, '0);
		send_request(CMD_TEST, '1);
		send_request(CMD_TEST, 32'd1);
		send_request(CMD_TEST, 32'h7FFF_FFFE);
		send_request(CMD_UNUSED, VAL_MAX);
		send_request(CMD_UNUSED, VAL_MIN);
		send_request(CMD_CLEAR, VAL_MAX);
		send_request(CMD_TEST, VAL_MAX);
		send_request(CMD_LOAD, 32'd1);
		send_request(CMD_TEST, 32'd1);
		send_request(CMD_TEST, '1);
		drain_results();

		run_sequences(300, 1'b1);
		drain_results();
		send_idle_pct = 65;
		recv_idle_pct = 11;
		run_sequences(300, 1'b0);
		drain_results();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_sequences(300, 1'b0);

		@(negedge clk);
		item_valid <= 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < 100_000) begin
			@(negedge clk);
			waited++;
		end
		repeat (300) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
